// ===== rtl/lse_pkg.sv =====
// Package for the LSB stego payload extractor: widths, register indexes,
// parser phase and result kind codes, shared structs. Depends on nothing.
package lse_pkg;

  // Width of the extension and payload length fields in the hidden stream.
  localparam int LENGTH_BITS = 32;
  localparam int BitCntW     = $clog2(LENGTH_BITS);

  localparam int HdrW   = 10;
  localparam int ByteW  = 8;
  localparam int CfgW   = 10;
  localparam int CfgIdxW = 2;

  localparam logic [HdrW-1:0]  HeaderLengthReset   = HdrW'(54);
  localparam logic [ByteW-1:0] MagicFirstReset     = ByteW'(35);
  localparam logic [ByteW-1:0] MagicSecondReset    = ByteW'(42);
  localparam logic [ByteW-1:0] ExtensionLimitReset = ByteW'(8);

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER_LENGTH   = 2'd0,
    REG_MAGIC_FIRST     = 2'd1,
    REG_MAGIC_SECOND    = 2'd2,
    REG_EXTENSION_LIMIT = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    KIND_EXT_CHAR  = 3'd0,
    KIND_PAY_BYTE  = 3'd1,
    KIND_EMPTY     = 3'd2,
    KIND_MAGIC_BAD = 3'd3,
    KIND_LEN_BAD   = 3'd4
  } kind_t;

  typedef enum logic [7:0] {
    PH_HEADER  = 8'b0000_0001,
    PH_MAGIC_A = 8'b0000_0010,
    PH_MAGIC_B = 8'b0000_0100,
    PH_EXT_LEN = 8'b0000_1000,
    PH_EXT     = 8'b0001_0000,
    PH_PAY_LEN = 8'b0010_0000,
    PH_PAY     = 8'b0100_0000,
    PH_STOP    = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [HdrW-1:0]  header_length;
    logic [ByteW-1:0] magic_first;
    logic [ByteW-1:0] magic_second;
    logic [ByteW-1:0] extension_limit;
  } cfg_t;

  typedef struct packed {
    kind_t            kind;
    logic [ByteW-1:0] value;
    logic             last;
  } result_t;

endpackage

// ===== rtl/lse_in_if.sv =====
// Input channel of the extractor: one cover-image byte per beat.
// Depends on lse_pkg.
interface lse_in_if;
  import lse_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] cover_byte;
  logic             frame_start;

  modport source (output valid, output cover_byte, output frame_start, input ready);
  modport sink   (input valid, input cover_byte, input frame_start, output ready);
endinterface

// ===== rtl/lse_out_if.sv =====
// Output channel of the extractor: one decoded result per beat.
// Depends on lse_pkg.
interface lse_out_if;
  import lse_pkg::*;

  logic             valid;
  logic             ready;
  kind_t            kind;
  logic [ByteW-1:0] value;
  logic             last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

// ===== rtl/lsb_stego_payload_extractor.sv =====
// LSB steganography payload extractor: takes one cover-image byte per beat,
// skips header_length bytes, then gathers bit 0 of each byte MSB first into
// two magic bytes, a LENGTH_BITS extension length, the extension characters,
// a LENGTH_BITS payload length and the payload bytes. One beat is taken every
// clock cycle while the skid stage is free: the parser updates its state in
// the cycle a byte is accepted and any result lands in a two-deep output
// register (result register plus a skid stage), so image.ready drops only
// while both hold a result; extract shows the result register. Kind 0 is
// an extension char, 1 a payload byte, 2 an empty payload, 3 a magic
// mismatch, 4 a bad extension length; last marks the final char or byte and
// every status result. After a status result or the final payload byte the
// block drops every byte until one arrives with frame_start set, which
// restarts parsing on that very byte. Registers: 0 header_length, 1
// magic_first, 2 magic_second, 3 extension_limit; write them only while idle.
// Depends on lse_pkg, lse_in_if, lse_out_if, lse_cfg_regs, lse_parser, lse_skid.
module lsb_stego_payload_extractor (
  input  logic                        clk,
  input  logic                        rst,
  lse_in_if.sink                      image,
  lse_out_if.source                   extract,
  input  logic                        cfg_we,
  input  logic [lse_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [lse_pkg::CfgW-1:0]    cfg_data
);
  import lse_pkg::*;

  cfg_t    cfg;
  logic    take;
  logic    can_push;
  logic    res_valid;
  result_t res;

  // Accept a beat whenever the skid stage is free.
  assign image.ready = can_push;
  assign take        = image.valid && can_push;

  lse_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lse_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .take        (take),
    .cover_byte  (image.cover_byte),
    .frame_start (image.frame_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Push a result only for an accepted beat that produced one.
  lse_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .push_data (res),
    .can_push  (can_push),
    .extract   (extract)
  );
endmodule

// ===== rtl/lse_cfg_regs.sv =====
// Configuration register file of the extractor (write only).
// Depends on lse_pkg.
module lse_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lse_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [lse_pkg::CfgW-1:0]     cfg_data,
  output lse_pkg::cfg_t                cfg
);
  import lse_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_length   <= HeaderLengthReset;
      cfg.magic_first     <= MagicFirstReset;
      cfg.magic_second    <= MagicSecondReset;
      cfg.extension_limit <= ExtensionLimitReset;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_HEADER_LENGTH:   cfg.header_length   <= cfg_data[HdrW-1:0];
        REG_MAGIC_FIRST:     cfg.magic_first     <= cfg_data[ByteW-1:0];
        REG_MAGIC_SECOND:    cfg.magic_second    <= cfg_data[ByteW-1:0];
        REG_EXTENSION_LIMIT: cfg.extension_limit <= cfg_data[ByteW-1:0];
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/lse_parser.sv =====
// Hidden-stream parser: one cover byte per accepted beat updates the phase
// state and yields at most one result. Depends on lse_pkg.
module lse_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  lse_pkg::cfg_t            cfg,
  input  logic                     take,
  input  logic [lse_pkg::ByteW-1:0] cover_byte,
  input  logic                     frame_start,
  output logic                     res_valid,
  output lse_pkg::result_t         res
);
  import lse_pkg::*;

  phase_t                   phase, phase_next;
  logic [HdrW-1:0]          header_counter, header_counter_next;
  logic [BitCntW-1:0]       bit_counter, bit_counter_next;
  logic [LENGTH_BITS-1:0]   bit_shift, bit_shift_next;
  logic [LENGTH_BITS-1:0]   bytes_remaining, bytes_remaining_next;
  logic                     magic_ok_flag, magic_ok_flag_next;

  phase_t                   ph;
  logic [HdrW-1:0]          hc;
  logic [BitCntW-1:0]       bc;
  logic [LENGTH_BITS-1:0]   sh;
  logic [LENGTH_BITS-1:0]   br;
  logic                     mok;
  logic                     shifting;
  logic                     full_byte;
  logic                     full_len;
  logic [LENGTH_BITS-1:0]   shifted;

  always_comb begin
    // Frame start clears everything, then the same byte is parsed.
    ph  = frame_start ? PH_HEADER : phase;
    hc  = frame_start ? '0 : header_counter;
    bc  = frame_start ? '0 : bit_counter;
    sh  = frame_start ? '0 : bit_shift;
    br  = frame_start ? '0 : bytes_remaining;
    mok = frame_start ? 1'b0 : magic_ok_flag;

    phase_next           = ph;
    header_counter_next  = hc;
    bit_counter_next     = bc;
    bit_shift_next       = sh;
    bytes_remaining_next = br;
    magic_ok_flag_next   = mok;
    res_valid            = 1'b0;
    res.kind             = KIND_EXT_CHAR;
    res.value            = '0;
    res.last             = 1'b0;

    shifted   = {sh[LENGTH_BITS-2:0], cover_byte[0]};
    full_byte = (bc == BitCntW'(ByteW - 1));
    full_len  = (bc == BitCntW'(LENGTH_BITS - 1));
    shifting  = 1'b1;

    if (ph == PH_HEADER) begin
      if (hc < cfg.header_length) begin
        header_counter_next = hc + HdrW'(1);
        shifting = 1'b0;
      end else begin
        ph = PH_MAGIC_A;
        phase_next = PH_MAGIC_A;
      end
    end
    if (ph == PH_STOP) begin
      shifting = 1'b0;
    end

    if (shifting) begin
      bit_shift_next = shifted;
      bit_counter_next = bc + BitCntW'(1);
      case (ph)
        PH_MAGIC_A: begin
          if (full_byte) begin
            bit_counter_next   = '0;
            magic_ok_flag_next = (shifted[ByteW-1:0] == cfg.magic_first);
            phase_next         = PH_MAGIC_B;
          end
        end
        PH_MAGIC_B: begin
          if (full_byte) begin
            bit_counter_next = '0;
            if (!mok || shifted[ByteW-1:0] != cfg.magic_second) begin
              phase_next = PH_STOP;
              res_valid  = 1'b1;
              res.kind   = KIND_MAGIC_BAD;
              res.last   = 1'b1;
            end else begin
              phase_next = PH_EXT_LEN;
            end
          end
        end
        PH_EXT_LEN: begin
          if (full_len) begin
            bit_counter_next = '0;
            if (shifted == '0 ||
                shifted >= LENGTH_BITS'(cfg.extension_limit)) begin
              phase_next = PH_STOP;
              res_valid  = 1'b1;
              res.kind   = KIND_LEN_BAD;
              res.last   = 1'b1;
            end else begin
              bytes_remaining_next = shifted;
              phase_next = PH_EXT;
            end
          end
        end
        PH_EXT: begin
          if (full_byte) begin
            bit_counter_next     = '0;
            bytes_remaining_next = br - LENGTH_BITS'(1);
            res_valid = 1'b1;
            res.kind  = KIND_EXT_CHAR;
            res.value = shifted[ByteW-1:0];
            if (br == LENGTH_BITS'(1)) begin
              res.last   = 1'b1;
              phase_next = PH_PAY_LEN;
            end
          end
        end
        PH_PAY_LEN: begin
          if (full_len) begin
            bit_counter_next     = '0;
            bytes_remaining_next = shifted;
            if (shifted == '0) begin
              phase_next = PH_STOP;
              res_valid  = 1'b1;
              res.kind   = KIND_EMPTY;
              res.last   = 1'b1;
            end else begin
              phase_next = PH_PAY;
            end
          end
        end
        PH_PAY: begin
          if (full_byte) begin
            bit_counter_next     = '0;
            bytes_remaining_next = br - LENGTH_BITS'(1);
            res_valid = 1'b1;
            res.kind  = KIND_PAY_BYTE;
            res.value = shifted[ByteW-1:0];
            if (br == LENGTH_BITS'(1)) begin
              res.last   = 1'b1;
              phase_next = PH_STOP;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_counter  <= '0;
      bit_counter     <= '0;
      bit_shift       <= '0;
      bytes_remaining <= '0;
      magic_ok_flag   <= 1'b0;
    end else if (take) begin
      phase           <= phase_next;
      header_counter  <= header_counter_next;
      bit_counter     <= bit_counter_next;
      bit_shift       <= bit_shift_next;
      bytes_remaining <= bytes_remaining_next;
      magic_ok_flag   <= magic_ok_flag_next;
    end
  end
endmodule

// ===== rtl/lse_skid.sv =====
// Result register with a skid stage behind it, so the input side keeps
// taking beats while a result waits. Depends on lse_pkg, lse_out_if.
module lse_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lse_pkg::result_t push_data,
  output logic             can_push,
  lse_out_if.source        extract
);
  import lse_pkg::*;

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    fire;

  assign fire     = out_valid && extract.ready;
  assign can_push = !skid_valid;

  assign extract.valid = out_valid;
  assign extract.kind  = out_data.kind;
  assign extract.value = out_data.value;
  assign extract.last  = out_data.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (fire) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push && !out_valid) begin
      out_data <= push_data;
    end
    if (push && out_valid && !fire) begin
      skid_data <= push_data;
    end
  end
endmodule
